>>> sv/wsdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_pkg: shared types and constants of the frame deframer
// Parse phases, result status codes and the command beat that passes from
// the header parser to the unmask stage.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extension byte counts and key length
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RSV      = 3'd2,
    ST_UNMASKED = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  // one result beat before unmasking
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    status_e    status;
  } cmd_t;

endpackage
`default_nettype wire

>>> sv/websocket_frame_deframer.sv
`default_nettype none
// Ordering: a result reaches the output ports through the queue and the
//   result register (the beat enters the queue at the accepting edge and
//   then moves into the result register), later while results wait.
// Throughput: one byte per cycle while the queue is not full, set by the
//   header parser and a QUEUE_DEPTH-entry queue ahead of the result register.
// Reset: asynchronous, active low; parser waits for a first header byte,
//   queue and result register are empty, max_len_q returns to 65536.
// ----------------------------------------------------------------------------
// websocket_frame_deframer: client frame parser with payload unmasking
// Parses frame headers byte by byte, rejects bad frames with an error-status
// beat, and delivers the unmasked payload bytes or an empty-frame marker as result beats.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsdf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        push,
  output var logic        full,
  input  var logic [7:0]  in_byte_i,
  output var logic        empty,
  input  var logic        pop,
  output var logic [7:0]  data_byte_o,
  output var logic [3:0]  frame_opcode_o,
  output var logic        frame_fin_o,
  output var logic        last_of_frame_o,
  output var logic [2:0]  result_status_o,
  input  var logic        cfg_valid,
  output var logic        cfg_ready,
  input  var logic [31:0] cfg_data_i
);

  logic [31:0] max_len_q;
  logic        accept;
  logic        cmd_valid;
  cmd_t        cmd_in;
  logic        q_avail;
  cmd_t        q_out;
  logic        q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // hold the payload limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_q <= cfg_data_i;
    end
  end

  wsdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (in_byte_i),
    .max_len_i   (max_len_q),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in)
  );

  wsdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .data_o  (q_out)
  );

  wsdf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_avail_i     (q_avail),
    .cmd_i           (q_out),
    .cmd_pop_o       (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .data_byte_o     (data_byte_o),
    .frame_opcode_o  (frame_opcode_o),
    .frame_fin_o     (frame_fin_o),
    .last_of_frame_o (last_of_frame_o),
    .result_status_o (result_status_o)
  );

endmodule
`default_nettype wire

>>> sv/wsdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_front: header parser
// Walks the frame header byte by byte, checks it, and issues one command
// beat per payload byte, empty frame or error.
// ----------------------------------------------------------------------------
module wsdf_front
  import wsdf_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        accept_i,
  input  var logic [7:0]  byte_i,
  input  var logic [31:0] max_len_i,
  output var logic        cmd_valid_o,
  output var cmd_t        cmd_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic        mask_q, mask_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [2:0]  key_left_q, key_left_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic        halt_q, halt_d;

  logic        active;
  logic        key_done;
  logic        rsv_bad;
  logic        too_long;
  logic        len_zero;
  logic        last_data;

  assign active    = accept_i && !halt_q;
  assign key_done  = (key_left_q == 3'd1);
  assign rsv_bad   = (hdr_q[6:4] != 3'd0);
  assign too_long  = (len_q[63:32] != 32'd0) || (len_q[31:0] > max_len_i);
  assign len_zero  = (len_q == 64'd0);
  assign last_data = (len_q == 64'd1);

  // next state of the parser
  always_comb begin
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    mask_d     = mask_q;
    ext_left_d = ext_left_q;
    key_left_d = key_left_q;
    len_d      = len_q;
    key_d      = key_q;
    key_idx_d  = key_idx_q;
    halt_d     = halt_q;
    if (active) begin
      unique case (phase_q)
        PH_HDR1: begin
          mask_d = byte_i[7];
          if (byte_i[6:0] == LEN_EXT16) begin
            len_d      = 64'd0;
            ext_left_d = EXT16_BYTES;
            phase_d    = PH_EXT;
          end else if (byte_i[6:0] == LEN_EXT64) begin
            len_d      = 64'd0;
            ext_left_d = EXT64_BYTES;
            phase_d    = PH_EXT;
          end else begin
            len_d      = {57'd0, byte_i[6:0]};
            key_left_d = KEY_BYTES;
            phase_d    = PH_KEY;
          end
        end
        PH_EXT: begin
          len_d      = {len_q[55:0], byte_i};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) begin
            key_left_d = KEY_BYTES;
            phase_d    = PH_KEY;
          end
        end
        PH_KEY: begin
          key_d      = {key_q[23:0], byte_i};
          key_left_d = key_left_q - 3'd1;
          if (key_done) begin
            if (rsv_bad || !mask_q || too_long) begin
              halt_d = 1'b1;
            end else if (len_zero) begin
              phase_d = PH_HDR0;
            end else begin
              key_idx_d = 2'd0;
              phase_d   = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          key_idx_d = key_idx_q + 2'd1;
          len_d     = len_q - 64'd1;
          if (last_data) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          hdr_d   = byte_i;
          phase_d = PH_HDR1;
        end
      endcase
    end
  end

  // command beat for the unmask stage
  always_comb begin
    cmd_valid_o   = 1'b0;
    cmd_o.raw     = 8'd0;
    cmd_o.key     = 8'd0;
    cmd_o.opcode  = hdr_q[3:0];
    cmd_o.fin     = hdr_q[7];
    cmd_o.last    = 1'b0;
    cmd_o.status  = ST_DATA;
    if (active) begin
      if (phase_q == PH_KEY && key_done) begin
        priority if (rsv_bad) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_RSV;
        end else if (!mask_q) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_UNMASKED;
        end else if (too_long) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_TOO_LONG;
        end else if (len_zero) begin
          cmd_valid_o  = 1'b1;
          cmd_o.last   = 1'b1;
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_valid_o = 1'b0;
        end
      end else if (phase_q == PH_DATA) begin
        cmd_valid_o = 1'b1;
        cmd_o.raw   = byte_i;
        cmd_o.key   = key_q[(3 - key_idx_q) * 8 +: 8];
        cmd_o.last  = last_data;
      end
    end
  end

  // hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      hdr_q      <= 8'd0;
      mask_q     <= 1'b0;
      ext_left_q <= 4'd0;
      key_left_q <= 3'd0;
      len_q      <= 64'd0;
      key_q      <= 32'd0;
      key_idx_q  <= 2'd0;
      halt_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_q      <= hdr_d;
      mask_q     <= mask_d;
      ext_left_q <= ext_left_d;
      key_left_q <= key_left_d;
      len_q      <= len_d;
      key_q      <= key_d;
      key_idx_q  <= key_idx_d;
      halt_q     <= halt_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/wsdf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_queue: command queue
// Small first-in first-out buffer of command beats between the parser and
// the unmask stage; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module wsdf_queue
  import wsdf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic push_i,
  input  var cmd_t data_i,
  output var logic full_o,
  input  var logic pop_i,
  output var logic avail_o,
  output var cmd_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign avail_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/wsdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsdf_back: unmask and result register
// Takes command beats from the queue, applies the key byte and holds the
// result on the output until it is popped.
// ----------------------------------------------------------------------------
module wsdf_back
  import wsdf_pkg::*;
(
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       cmd_avail_i,
  input  var cmd_t       cmd_i,
  output var logic       cmd_pop_o,
  input  var logic       pop_i,
  output var logic       empty_o,
  output var logic [7:0] data_byte_o,
  output var logic [3:0] frame_opcode_o,
  output var logic       frame_fin_o,
  output var logic       last_of_frame_o,
  output var logic [2:0] result_status_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic [3:0] opcode_q;
  logic       fin_q;
  logic       last_q;
  status_e    status_q;
  logic       load;

  // refill when the register is free or being popped
  assign load      = cmd_avail_i && (!valid_q || pop_i);
  assign cmd_pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // unmask into the result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= cmd_i.raw ^ cmd_i.key;
      opcode_q <= cmd_i.opcode;
      fin_q    <= cmd_i.fin;
      last_q   <= cmd_i.last;
      status_q <= cmd_i.status;
    end
  end

  assign empty_o         = !valid_q;
  assign data_byte_o     = data_q;
  assign frame_opcode_o  = opcode_q;
  assign frame_fin_o     = fin_q;
  assign last_of_frame_o = last_q;
  assign result_status_o = status_q;

endmodule
`default_nettype wire
